// File: design/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants of the text console writer: default screen size, field
// widths, operation codes, control characters and cell attributes.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  // default screen geometry
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // transaction field widths
  localparam int OP_W     = 2;
  localparam int CHAR_W   = 8;
  localparam int COLOR_W  = 4;
  localparam int ATTR_W   = 8;
  localparam int INDEX_W  = 11;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // control characters
  localparam logic [CHAR_W-1:0] CODE_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CODE_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CODE_DELETE  = 8'd127;
  localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'h20;

  // cell attributes
  localparam logic [ATTR_W-1:0] BLANK_ATTR = 8'h0F;
  localparam logic [ATTR_W-1:0] GRAY_ATTR  = 8'h07;

endpackage

`default_nettype wire

// File: design/tcw_screen_mem.sv
// ----------------------------------------------------------------------------
// tcw_screen_mem
// Screen storage: one character memory and one attribute memory, one write
// port and one registered read port each, sharing addresses.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_screen_mem #(
  parameter int DEPTH = tcw_pkg::ROWS_DEF * tcw_pkg::COLUMNS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                      clk_i,
  input  wire logic                      char_we_i,
  input  wire logic                      attr_we_i,
  input  wire logic [AW-1:0]             waddr_i,
  input  wire logic [tcw_pkg::CHAR_W-1:0] wchar_i,
  input  wire logic [tcw_pkg::ATTR_W-1:0] wattr_i,
  input  wire logic [AW-1:0]             raddr_i,
  output logic      [tcw_pkg::CHAR_W-1:0] rchar_o,
  output logic      [tcw_pkg::ATTR_W-1:0] rattr_o
);

  logic [tcw_pkg::CHAR_W-1:0] char_mem [DEPTH];
  logic [tcw_pkg::ATTR_W-1:0] attr_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (char_we_i) begin
      char_mem[waddr_i] <= wchar_i;
    end
    rchar_o <= char_mem[raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (attr_we_i) begin
      attr_mem[waddr_i] <= wattr_i;
    end
    rattr_o <= attr_mem[raddr_i];
  end

endmodule

`default_nettype wire

// File: design/text_console_writer_core.sv
// ----------------------------------------------------------------------------
// text_console_writer_core
// Text screen of ROWS x COLUMNS character/attribute cells with a write cursor.
//
// Input channel (in_valid_i / in_stall_o) carries one command per transaction:
// put a character, read a cell or clear the screen. Output channel
// (out_valid_o / out_stall_i) returns exactly one result per command, in order.
// Cells live in two single-port-write memories with a registered read port.
// Per command: an ordinary put writes one cell and a read reads one cell;
//   delete, an out-of-range read and an unused op finish on acceptance;
//   newline writes blanks up to the end of the row, tab writes four blanks,
//   clear blanks the character of every cell.
//   Each scroll adds a row copy walk plus a bottom fill, both of which go
//   through the single memory write port.
// Commands are processed one at a time; the next one is taken as soon as the
// sequencer is idle and the result register is empty or being drained.
// A stalled result holds in the output register and blocks further commands.
// After reset the block sweeps the screen to space/0x0F with in_stall_o high;
// the cursor resets to cell 0.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer_core #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [tcw_pkg::OP_W-1:0]    op_i,
  input  wire logic [tcw_pkg::CHAR_W-1:0]  char_code_i,
  input  wire logic [tcw_pkg::COLOR_W-1:0] fg_color_i,
  input  wire logic [tcw_pkg::COLOR_W-1:0] bg_color_i,
  input  wire logic [tcw_pkg::INDEX_W-1:0] cell_index_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic      [tcw_pkg::CHAR_W-1:0]  read_char_o,
  output logic      [tcw_pkg::ATTR_W-1:0]  read_attr_o,
  output logic      [tcw_pkg::INDEX_W-1:0] cursor_pos_o,
  output logic                             scrolled_o
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);

  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0] LAST_ROW  = AW'(CELLS - COLUMNS);
  localparam logic [AW-1:0] COL_STEP  = AW'(COLUMNS);
  localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_PUT  = 3'd2;
  localparam logic [2:0] S_READ = 3'd3;
  localparam logic [2:0] S_CLR  = 3'd4;
  localparam logic [2:0] S_SCR  = 3'd5;
  localparam logic [2:0] S_FILL = 3'd6;

  localparam logic [1:0] MODE_SINGLE  = 2'd0;
  localparam logic [1:0] MODE_NEWLINE = 2'd1;
  localparam logic [1:0] MODE_TAB     = 2'd2;

  logic [2:0]                  state_q, state_d;
  logic [AW-1:0]               cnt_q, cnt_d;
  logic [AW-1:0]               cursor_q, cursor_d;
  logic [CW-1:0]               col_q, col_d;
  logic [1:0]                  mode_q, mode_d;
  logic [1:0]                  tab_cnt_q, tab_cnt_d;
  logic                        more_q, more_d;
  logic                        scr_q, scr_d;
  logic                        cp_pend_q, cp_pend_d;
  logic [AW-1:0]               cp_addr_q, cp_addr_d;
  logic [tcw_pkg::CHAR_W-1:0]  char_q, char_d;
  logic [tcw_pkg::ATTR_W-1:0]  attr_q, attr_d;

  logic                        out_valid_q, out_valid_d;
  logic [tcw_pkg::CHAR_W-1:0]  read_char_q;
  logic [tcw_pkg::ATTR_W-1:0]  read_attr_q;
  logic [tcw_pkg::INDEX_W-1:0] cursor_pos_q;
  logic                        scrolled_q;

  logic                        accept_ok;
  logic                        in_accept;
  logic                        finish;
  logic [tcw_pkg::CHAR_W-1:0]  fin_char;
  logic [tcw_pkg::ATTR_W-1:0]  fin_attr;

  logic                        char_we;
  logic                        attr_we;
  logic [AW-1:0]               waddr;
  logic [tcw_pkg::CHAR_W-1:0]  wchar;
  logic [tcw_pkg::ATTR_W-1:0]  wattr;
  logic [AW-1:0]               raddr;
  logic [tcw_pkg::CHAR_W-1:0]  rchar;
  logic [tcw_pkg::ATTR_W-1:0]  rattr;

  logic [AW:0]                 cur_inc;
  logic [CW-1:0]               col_nx;
  logic                        more;

  tcw_screen_mem #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .char_we_i (char_we),
    .attr_we_i (attr_we),
    .waddr_i   (waddr),
    .wchar_i   (wchar),
    .wattr_i   (wattr),
    .raddr_i   (raddr),
    .rchar_o   (rchar),
    .rattr_o   (rattr)
  );

  // result register is free at acceptance, so it is free when the command ends
  assign accept_ok  = (state_q == S_IDLE) && (!out_valid_q || !out_stall_i);
  assign in_accept  = in_valid_i && accept_ok;
  assign in_stall_o = !accept_ok;

  // one cursor step for the put loop
  always_comb begin
    cur_inc = {1'b0, cursor_q} + (AW+1)'(1);
    col_nx  = (col_q == LAST_COL) ? '0 : col_q + CW'(1);
    unique case (mode_q)
      MODE_NEWLINE: more = (col_nx != '0);
      MODE_TAB:     more = (tab_cnt_q != 2'd0);
      default:      more = 1'b0;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    cursor_d  = cursor_q;
    col_d     = col_q;
    mode_d    = mode_q;
    tab_cnt_d = tab_cnt_q;
    more_d    = more_q;
    scr_d     = scr_q;
    cp_pend_d = 1'b0;
    cp_addr_d = cp_addr_q;
    char_d    = char_q;
    attr_d    = attr_q;
    finish    = 1'b0;
    fin_char  = '0;
    fin_attr  = '0;
    char_we   = 1'b0;
    attr_we   = 1'b0;
    waddr     = cnt_q;
    wchar     = tcw_pkg::SPACE_CHAR;
    wattr     = tcw_pkg::BLANK_ATTR;
    raddr     = cnt_q;

    unique case (state_q)
      S_INIT: begin
        char_we = 1'b1;
        attr_we = 1'b1;
        if (cnt_q == LAST_CELL) begin
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end

      S_IDLE: begin
        if (in_accept) begin
          scr_d = 1'b0;
          unique case (op_i)
            tcw_pkg::OP_PUT: begin
              case (char_code_i)
                tcw_pkg::CODE_NEWLINE: begin
                  char_d  = tcw_pkg::SPACE_CHAR;
                  attr_d  = tcw_pkg::GRAY_ATTR;
                  mode_d  = MODE_NEWLINE;
                  state_d = S_PUT;
                end
                tcw_pkg::CODE_TAB: begin
                  char_d    = tcw_pkg::SPACE_CHAR;
                  attr_d    = tcw_pkg::GRAY_ATTR;
                  mode_d    = MODE_TAB;
                  tab_cnt_d = 2'd3;
                  state_d   = S_PUT;
                end
                tcw_pkg::CODE_DELETE: begin
                  // step back, blank the character, keep the attribute
                  if (cursor_q != '0) begin
                    char_we  = 1'b1;
                    waddr    = cursor_q - AW'(1);
                    cursor_d = cursor_q - AW'(1);
                    col_d    = (col_q == '0) ? LAST_COL : col_q - CW'(1);
                  end
                  finish = 1'b1;
                end
                default: begin
                  char_d  = char_code_i;
                  attr_d  = {bg_color_i, fg_color_i};
                  mode_d  = MODE_SINGLE;
                  state_d = S_PUT;
                end
              endcase
            end
            tcw_pkg::OP_READ: begin
              if (32'(cell_index_i) < 32'(CELLS)) begin
                raddr   = AW'(cell_index_i);
                state_d = S_READ;
              end else begin
                finish = 1'b1;
              end
            end
            tcw_pkg::OP_CLEAR: begin
              cnt_d   = '0;
              state_d = S_CLR;
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
      end

      S_PUT: begin
        char_we = 1'b1;
        attr_we = 1'b1;
        waddr   = cursor_q;
        wchar   = char_q;
        wattr   = attr_q;
        if (mode_q == MODE_TAB && tab_cnt_q != 2'd0) begin
          tab_cnt_d = tab_cnt_q - 2'd1;
        end
        if (cur_inc == (AW+1)'(CELLS)) begin
          cursor_d = LAST_ROW;
          col_d    = '0;
          scr_d    = 1'b1;
          more_d   = more;
          cnt_d    = COL_STEP;
          state_d  = S_SCR;
        end else begin
          cursor_d = cur_inc[AW-1:0];
          col_d    = col_nx;
          if (!more) begin
            finish  = 1'b1;
            state_d = S_IDLE;
          end
        end
      end

      S_READ: begin
        fin_char = rchar;
        fin_attr = rattr;
        finish   = 1'b1;
        state_d  = S_IDLE;
      end

      S_CLR: begin
        char_we = 1'b1;
        if (cnt_q == LAST_CELL) begin
          cursor_d = '0;
          col_d    = '0;
          finish   = 1'b1;
          state_d  = S_IDLE;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end

      S_SCR: begin
        // read one row ahead, written back on the next cycle
        cp_pend_d = 1'b1;
        cp_addr_d = cnt_q - COL_STEP;
        if (cnt_q == LAST_CELL) begin
          cnt_d   = LAST_ROW;
          state_d = S_FILL;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end

      S_FILL: begin
        // waits while the last copied cell takes the write port
        if (!cp_pend_q) begin
          char_we = 1'b1;
          attr_we = 1'b1;
          if (cnt_q == LAST_CELL) begin
            if (more_q) begin
              state_d = S_PUT;
            end else begin
              finish  = 1'b1;
              state_d = S_IDLE;
            end
          end else begin
            cnt_d = cnt_q + AW'(1);
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // pending row copy owns the write port
    if (cp_pend_q) begin
      char_we = 1'b1;
      attr_we = 1'b1;
      waddr   = cp_addr_q;
      wchar   = rchar;
      wattr   = rattr;
    end
  end

  always_comb begin
    if (finish) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      cnt_q       <= '0;
      cursor_q    <= '0;
      col_q       <= '0;
      mode_q      <= MODE_SINGLE;
      tab_cnt_q   <= 2'd0;
      more_q      <= 1'b0;
      scr_q       <= 1'b0;
      cp_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      cursor_q    <= cursor_d;
      col_q       <= col_d;
      mode_q      <= mode_d;
      tab_cnt_q   <= tab_cnt_d;
      more_q      <= more_d;
      scr_q       <= scr_d;
      cp_pend_q   <= cp_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cp_addr_q <= cp_addr_d;
    char_q    <= char_d;
    attr_q    <= attr_d;
    if (finish) begin
      read_char_q  <= fin_char;
      read_attr_q  <= fin_attr;
      cursor_pos_q <= tcw_pkg::INDEX_W'(cursor_d);
      scrolled_q   <= scr_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_char_o  = read_char_q;
  assign read_attr_o  = read_attr_q;
  assign cursor_pos_o = cursor_pos_q;
  assign scrolled_o   = scrolled_q;

endmodule

`default_nettype wire

// File: tb/tb_text_console_writer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_writer_core
// Self-checking bench for the text console writer. Commands go in through the
// valid/stall input channel. A shadow copy of the screen and cursor predicts
// every result, and each returned transaction is compared field by field. The
// run covers directed corners, fills to the bottom row so that the screen
// scrolls, and random traffic under varying idle and stall patterns.
// ----------------------------------------------------------------------------

module tb_text_console_writer_core;

  localparam int COLUMNS = tcw_pkg::COLUMNS_DEF;
  localparam int ROWS    = tcw_pkg::ROWS_DEF;
  localparam int CELLS   = COLUMNS * ROWS;

  // the package leaves op 3 unnamed, and the block treats it as a no-op
  localparam logic [tcw_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [tcw_pkg::CHAR_W-1:0]  rd_char;
    logic [tcw_pkg::ATTR_W-1:0]  rd_attr;
    logic [tcw_pkg::INDEX_W-1:0] cursor;
    logic                        scrolled;
  } console_result_t;

  logic                          clk_i;
  logic                          rst_ni       = 1'b0;
  logic                          in_valid_i   = 1'b0;
  logic                          in_stall_o;
  logic [tcw_pkg::OP_W-1:0]      op_i         = '0;
  logic [tcw_pkg::CHAR_W-1:0]    char_code_i  = '0;
  logic [tcw_pkg::COLOR_W-1:0]   fg_color_i   = '0;
  logic [tcw_pkg::COLOR_W-1:0]   bg_color_i   = '0;
  logic [tcw_pkg::INDEX_W-1:0]   cell_index_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i  = 1'b0;
  logic [tcw_pkg::CHAR_W-1:0]    read_char_o;
  logic [tcw_pkg::ATTR_W-1:0]    read_attr_o;
  logic [tcw_pkg::INDEX_W-1:0]   cursor_pos_o;
  logic                          scrolled_o;

  // shadow screen: char in the low byte, attribute in the high byte
  logic [15:0]          shadow_screen [0:CELLS-1];
  int                   shadow_cursor;
  logic                 shadow_scrolled;
  console_result_t      pending_results [$];

  int                   mismatches   = 0;
  int                   tx_idle_pct  = 0;
  int                   rx_idle_pct  = 0;
  int                   rx_hold_left = 0;

  text_console_writer_core #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .char_code_i (char_code_i),
    .fg_color_i  (fg_color_i),
    .bg_color_i  (bg_color_i),
    .cell_index_i(cell_index_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .read_char_o (read_char_o),
    .read_attr_o (read_attr_o),
    .cursor_pos_o(cursor_pos_o),
    .scrolled_o  (scrolled_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #60000000;
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // screen prediction
  // ---------------------------------------------------------------------------
  function automatic void write_cell(input logic [tcw_pkg::CHAR_W-1:0] ch,
                                     input logic [tcw_pkg::ATTR_W-1:0] attr);
    int i;
    if (shadow_cursor >= CELLS) shadow_cursor = 0;
    shadow_screen[shadow_cursor] = {attr, ch};
    shadow_cursor++;
    // hitting the end shifts every row up and blanks the bottom one
    if (shadow_cursor >= CELLS) begin
      for (i = 0; i < CELLS - COLUMNS; i++) shadow_screen[i] = shadow_screen[i + COLUMNS];
      for (i = CELLS - COLUMNS; i < CELLS; i++) begin
        shadow_screen[i] = {tcw_pkg::BLANK_ATTR, tcw_pkg::SPACE_CHAR};
      end
      shadow_cursor   = CELLS - COLUMNS;
      shadow_scrolled = 1'b1;
    end
  endfunction

  function automatic console_result_t apply_command(
    input logic [tcw_pkg::OP_W-1:0]    op,
    input logic [tcw_pkg::CHAR_W-1:0]  ch,
    input logic [tcw_pkg::COLOR_W-1:0] fg,
    input logic [tcw_pkg::COLOR_W-1:0] bg,
    input logic [tcw_pkg::INDEX_W-1:0] idx
  );
    console_result_t res;
    int i;
    res = '0;
    shadow_scrolled = 1'b0;
    case (op)
      tcw_pkg::OP_PUT: begin
        if (ch == tcw_pkg::CODE_NEWLINE) begin
          do write_cell(tcw_pkg::SPACE_CHAR, tcw_pkg::GRAY_ATTR);
          while (shadow_cursor % COLUMNS != 0);
        end else if (ch == tcw_pkg::CODE_TAB) begin
          repeat (4) write_cell(tcw_pkg::SPACE_CHAR, tcw_pkg::GRAY_ATTR);
        end else if (ch == tcw_pkg::CODE_DELETE) begin
          // step back first, then blank; attribute survives
          if (shadow_cursor > 0 && shadow_cursor < CELLS) begin
            shadow_cursor--;
            shadow_screen[shadow_cursor][7:0] = tcw_pkg::SPACE_CHAR;
          end
        end else begin
          write_cell(ch, {bg, fg});
        end
      end
      tcw_pkg::OP_READ: begin
        if (idx < CELLS) {res.rd_attr, res.rd_char} = shadow_screen[idx];
      end
      tcw_pkg::OP_CLEAR: begin
        for (i = 0; i < CELLS; i++) shadow_screen[i][7:0] = tcw_pkg::SPACE_CHAR;
        shadow_cursor = 0;
      end
      default: begin
      end
    endcase
    res.cursor   = tcw_pkg::INDEX_W'(shadow_cursor);
    res.scrolled = shadow_scrolled;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic send_cmd(input logic [tcw_pkg::OP_W-1:0]    op,
                          input logic [tcw_pkg::CHAR_W-1:0]  ch,
                          input logic [tcw_pkg::COLOR_W-1:0] fg,
                          input logic [tcw_pkg::COLOR_W-1:0] bg,
                          input logic [tcw_pkg::INDEX_W-1:0] idx);
    int gap;
    @(negedge clk_i);
    if ($urandom_range(99) < tx_idle_pct) begin
      gap = $urandom_range(1, 3);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    op_i         <= op;
    char_code_i  <= ch;
    fg_color_i   <= fg;
    bg_color_i   <= bg;
    cell_index_i <= idx;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(apply_command(op, ch, fg, bg, idx));
  endtask

  task automatic send_put(input logic [tcw_pkg::CHAR_W-1:0] ch);
    send_cmd(tcw_pkg::OP_PUT, ch, tcw_pkg::COLOR_W'($urandom_range(15)),
             tcw_pkg::COLOR_W'($urandom_range(15)), tcw_pkg::INDEX_W'($urandom_range(2047)));
  endtask

  task automatic send_read(input logic [tcw_pkg::INDEX_W-1:0] idx);
    send_cmd(tcw_pkg::OP_READ, tcw_pkg::CHAR_W'($urandom_range(255)),
             tcw_pkg::COLOR_W'($urandom_range(15)), tcw_pkg::COLOR_W'($urandom_range(15)),
             idx);
  endtask

  task automatic send_random_cmd();
    int pick;
    logic [tcw_pkg::OP_W-1:0]    op;
    logic [tcw_pkg::CHAR_W-1:0]  ch;
    logic [tcw_pkg::INDEX_W-1:0] idx;
    pick = $urandom_range(199);
    op   = tcw_pkg::OP_PUT;
    ch   = tcw_pkg::CHAR_W'($urandom_range(255));
    idx  = tcw_pkg::INDEX_W'($urandom_range(2047));
    if (pick < 90) begin
    end else if (pick < 110) begin
      ch = tcw_pkg::CODE_NEWLINE;
    end else if (pick < 124) begin
      ch = tcw_pkg::CODE_TAB;
    end else if (pick < 140) begin
      ch = tcw_pkg::CODE_DELETE;
    end else if (pick < 176) begin
      // mostly look at what was just written
      op  = tcw_pkg::OP_READ;
      idx = tcw_pkg::INDEX_W'((shadow_cursor + CELLS - $urandom_range(0, 160)) % CELLS);
    end else if (pick < 190) begin
      op = tcw_pkg::OP_READ;
    end else if (pick < 198) begin
      op = OP_UNUSED;
    end else begin
      op = tcw_pkg::OP_CLEAR;
    end
    send_cmd(op, ch, tcw_pkg::COLOR_W'($urandom_range(15)),
             tcw_pkg::COLOR_W'($urandom_range(15)), idx);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    send_read(11'd0);
    send_read(tcw_pkg::INDEX_W'(CELLS - 1));
    send_read(tcw_pkg::INDEX_W'(CELLS));
    send_read(11'h7FF);
    send_cmd(tcw_pkg::OP_PUT, 8'h00, 4'h0, 4'h0, 11'h000);
    send_cmd(tcw_pkg::OP_PUT, 8'hFF, 4'hF, 4'hF, 11'h7FF);
    send_cmd(tcw_pkg::OP_PUT, 8'h55, 4'hA, 4'h5, 11'h555);
    send_cmd(tcw_pkg::OP_PUT, 8'hAA, 4'h5, 4'hA, 11'h2AA);
    send_put(tcw_pkg::CODE_TAB);
    send_put(tcw_pkg::CODE_DELETE);
    send_put(tcw_pkg::CODE_NEWLINE);
    // newline from a row start writes a full row
    send_put(tcw_pkg::CODE_NEWLINE);
    // delete at a row start steps back onto the previous row
    send_put(tcw_pkg::CODE_DELETE);
    send_read(tcw_pkg::INDEX_W'(2 * COLUMNS - 1));
    send_read(11'd1);
    send_cmd(OP_UNUSED, 8'hFF, 4'hF, 4'hF, 11'h7FF);
    send_cmd(tcw_pkg::OP_CLEAR, 8'h00, 4'h0, 4'h0, 11'h000);
    send_read(11'd0);
    send_read(11'd1);
    send_put(tcw_pkg::CODE_DELETE);
    send_read(11'd1024);
  endtask

  // run the cursor down to the bottom row, then force a scroll
  task automatic test_fill_to_bottom();
    while (shadow_cursor < CELLS - COLUMNS) send_put(tcw_pkg::CODE_NEWLINE);
    repeat ($urandom_range(1, 6)) send_put(tcw_pkg::CHAR_W'($urandom_range(32, 126)));
    send_put(tcw_pkg::CODE_NEWLINE);
    send_read(tcw_pkg::INDEX_W'(CELLS - COLUMNS - 1));
  endtask

  task automatic test_random(input int count);
    repeat (count) send_random_cmd();
  endtask

  // receiver holds off while commands keep coming, so the block backs up
  task automatic test_backpressure();
    rx_hold_left = 300;
    repeat (12) send_random_cmd();
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rx_hold_left > 0) begin
      rx_hold_left <= rx_hold_left - 1;
      out_stall_i  <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  function automatic void check_field(input string field, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    console_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected transaction, expected none, actual char 0x%0h cursor %0d",
                 $time, read_char_o, cursor_pos_o);
      end else begin
        want = pending_results.pop_front();
        check_field("read_char", want.rd_char, read_char_o);
        check_field("read_attr", want.rd_attr, read_attr_o);
        check_field("cursor_pos", want.cursor, cursor_pos_o);
        check_field("scrolled", want.scrolled, scrolled_o);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    int i;
    int waited;
    for (i = 0; i < CELLS; i++) shadow_screen[i] = {tcw_pkg::BLANK_ATTR, tcw_pkg::SPACE_CHAR};
    shadow_cursor   = 0;
    shadow_scrolled = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    tx_idle_pct = 12;
    rx_idle_pct = 52;
    test_directed();
    test_fill_to_bottom();
    test_random(130);

    tx_idle_pct = 52;
    rx_idle_pct = 12;
    test_fill_to_bottom();
    test_backpressure();
    test_random(120);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_fill_to_bottom();
    test_random(130);

    @(negedge clk_i);
    in_valid_i <= 1'b0;

    waited = 0;
    while (pending_results.size() != 0 && waited < 50000) begin
      @(posedge clk_i);
      waited++;
    end
    // a clear or scroll can keep the block busy for a full screen walk
    repeat (2200) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      mismatches++;
      $display("%0t: %0d transactions never returned", $time, pending_results.size());
    end

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
